FILE: src/gdn_pkg.sv
// gdn_pkg: shared types, widths, tables and helper functions of the
// gregorian day number converter. No dependencies.
`default_nettype none

package gdn_pkg;

  // default last supported year
  localparam int unsigned YEAR_MAX_DEF = 9999;

  // port field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned ABS_W   = 22;
  localparam int unsigned NTH_W   = 4;
  localparam int unsigned WDAY_W  = 3;

  // internal widths, sized for the largest supported year (65535)
  localparam int unsigned YR_W    = 17;
  localparam int unsigned DAY_W   = 26;
  localparam int unsigned SUM_W   = DAY_W + 1;
  localparam int unsigned DIV_W   = DAY_W;
  localparam int unsigned RCP_W   = 24;
  localparam int unsigned REM_W   = 9;
  localparam int unsigned PROD_W  = DIV_W + RCP_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_TO_ABS   = 2'd0;
  localparam logic [OP_W-1:0] OP_TO_DATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_NTH_WDAY = 2'd2;

  // constant divisors and their scaled reciprocals
  localparam logic [REM_W-1:0] DIVISOR_7   = 9'd7;
  localparam logic [REM_W-1:0] DIVISOR_100 = 9'd100;
  localparam logic [REM_W-1:0] DIVISOR_366 = 9'd366;
  localparam logic [RCP_W-1:0] RCP_7   = RCP_W'((64'd1 << DIV_W) / 7);
  localparam logic [RCP_W-1:0] RCP_100 = RCP_W'((64'd1 << DIV_W) / 100);
  localparam logic [RCP_W-1:0] RCP_366 = RCP_W'((64'd1 << DIV_W) / 366);

  typedef enum logic [1:0] {
    DIV_BY_7,
    DIV_BY_100,
    DIV_BY_366
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LEAP,
    S_FIX,
    S_WK_GO,
    S_WK,
    S_YDIV_GO,
    S_YDIV,
    S_YCEN_GO,
    S_YCEN,
    S_YEAR,
    S_MONTH,
    S_ERR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    div_sel_e         sel;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year_out;
    logic [MON_W-1:0]  month_out;
    logic [MDAY_W-1:0] day_out;
    logic [ABS_W-1:0]  absolute_out;
    logic              out_of_range;
  } result_t;

  function automatic logic [REM_W-1:0] div_const(input div_sel_e sel);
    case (sel)
      DIV_BY_7:   return DIVISOR_7;
      DIV_BY_100: return DIVISOR_100;
      default:    return DIVISOR_366;
    endcase
  endfunction

  function automatic logic [RCP_W-1:0] div_recip(input div_sel_e sel);
    case (sel)
      DIV_BY_7:   return RCP_7;
      DIV_BY_100: return RCP_100;
      default:    return RCP_366;
    endcase
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((m > 4'd2) && leap);
  endfunction

  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    if (m == 4'd2) begin
      return leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      return 5'd30;
    end
    return 5'd31;
  endfunction

  // 365*v + v/4 - v/100 + v/400, with q = v/100 from the divider
  function automatic logic [DAY_W-1:0] year_base(input logic [YR_W-1:0] v,
                                                 input logic [YR_W-1:0] q);
    logic [DAY_W-1:0] vx;
    logic [DAY_W-1:0] qx;
    vx = DAY_W'(v);
    qx = DAY_W'(q);
    return vx * DAY_W'(365) + (vx >> 2) - qx + (qx >> 2);
  endfunction

endpackage

`default_nettype wire

FILE: src/gdn_if.sv
// gdn_req_if / gdn_rsp_if: valid-ready channels of the day number converter.
// Depends on gdn_pkg for field widths.
`default_nettype none

interface gdn_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [gdn_pkg::OP_W-1:0]               operation;
  logic [gdn_pkg::YEAR_W-1:0]             year_in;
  logic [gdn_pkg::MON_W-1:0]              month_in;
  logic [gdn_pkg::MDAY_W-1:0]             day_in;
  logic [gdn_pkg::ABS_W-1:0]              absolute_in;
  logic signed [gdn_pkg::NTH_W-1:0]       nth;
  logic [gdn_pkg::WDAY_W-1:0]             weekday;

  modport source(output valid, operation, year_in, month_in, day_in, absolute_in, nth,
                 weekday, input ready);
  modport sink(input valid, operation, year_in, month_in, day_in, absolute_in, nth,
               weekday, output ready);
endinterface

interface gdn_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gdn_pkg::YEAR_W-1:0]   year_out;
  logic [gdn_pkg::MON_W-1:0]    month_out;
  logic [gdn_pkg::MDAY_W-1:0]   day_out;
  logic [gdn_pkg::ABS_W-1:0]    absolute_out;
  logic                         out_of_range;

  modport source(output valid, year_out, month_out, day_out, absolute_out, out_of_range,
                 input ready);
  modport sink(input valid, year_out, month_out, day_out, absolute_out, out_of_range,
               output ready);
endinterface

`default_nettype wire

FILE: src/gregorian_day_number_convert.sv
// gregorian_day_number_convert: top level of the day number converter.
// Depends on gdn_pkg, gdn_if, gdn_div and gdn_core.
//
// Converts proleptic Gregorian dates (years 1 to YEAR_MAX, day 1 = 0001-01-01)
// to absolute day numbers and back, and finds the nth weekday around a date.
// One transaction is in work at a time; req_i.ready is high only while the
// sequencer is idle, and a finished result waits in an output register so
// the next request can be taken while rsp_o is stalled. All divisions go
// through one shared constant divider, and the day to date direction then
// steps the year up one per cycle and the month up one per cycle. A bad
// operation, year, month, absolute day or day of month, or an nth weekday
// landing outside the range, finishes with out_of_range set and every other
// field zero. The sequencer returns to its idle state between requests.
`default_nettype none

module gregorian_day_number_convert #(
  parameter int unsigned YEAR_MAX = gdn_pkg::YEAR_MAX_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gdn_req_if.sink     req_i,
  gdn_rsp_if.source   rsp_o
);

  gdn_pkg::div_req_t  div_req;
  gdn_pkg::div_rsp_t  div_rsp;
  gdn_pkg::result_t   res;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_q;
  gdn_pkg::result_t   out_q;

  gdn_core #(
    .YEAR_MAX(YEAR_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  gdn_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // output register
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.year_out     = out_q.year_out;
  assign rsp_o.month_out    = out_q.month_out;
  assign rsp_o.day_out      = out_q.day_out;
  assign rsp_o.absolute_out = out_q.absolute_out;
  assign rsp_o.out_of_range = out_q.out_of_range;

endmodule

`default_nettype wire

FILE: src/gdn_div.sv
// gdn_div: shared divider by a constant (7, 100 or 366), reciprocal multiply
// with one correction step. Depends on gdn_pkg.
`default_nettype none

module gdn_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gdn_pkg::div_req_t req_i,
  output gdn_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned DW = gdn_pkg::DIV_W;
  localparam int unsigned RW = gdn_pkg::RCP_W;
  localparam int unsigned MW = gdn_pkg::REM_W;
  localparam int unsigned PW = gdn_pkg::PROD_W;

  logic                v0_q, v1_q, v2_q, v3_q;
  logic [DW-1:0]       x0_q, x1_q, x2_q, x3_q;
  gdn_pkg::div_sel_e   sel0_q, sel1_q, sel2_q, sel3_q;
  logic [PW-1:0]       prod1_q;
  logic [RW-1:0]       q2_q, quot_q;
  logic [MW:0]         r2_q;
  logic [MW-1:0]       rem_q;

  logic [RW-1:0]       q_est;
  logic [DW-1:0]       r_full;
  logic [MW:0]         r_est;
  logic [MW:0]         dv2;
  logic [RW-1:0]       q_fix;
  logic [MW:0]         r_fix;

  // estimate, remainder, single correction
  always_comb begin
    q_est  = prod1_q[PW-1:DW];
    r_full = x1_q - DW'(q_est) * DW'(gdn_pkg::div_const(sel1_q));
    r_est  = r_full[MW:0];
    dv2    = (MW+1)'(gdn_pkg::div_const(sel2_q));
    if (r2_q >= dv2) begin
      q_fix = q2_q + RW'(1);
      r_fix = r2_q - dv2;
    end else begin
      q_fix = q2_q;
      r_fix = r2_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= req_i.start;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x0_q   <= req_i.dividend;
      sel0_q <= req_i.sel;
    end
    if (v0_q) begin
      x1_q    <= x0_q;
      sel1_q  <= sel0_q;
      prod1_q <= PW'(x0_q) * PW'(gdn_pkg::div_recip(sel0_q));
    end
    if (v1_q) begin
      x2_q   <= x1_q;
      sel2_q <= sel1_q;
      q2_q   <= q_est;
      r2_q   <= r_est;
    end
    if (v2_q) begin
      x3_q   <= x2_q;
      sel3_q <= sel2_q;
      quot_q <= q_fix;
      rem_q  <= r_fix[MW-1:0];
    end
  end

  assign rsp_o.done = v3_q;
  assign rsp_o.quot = DW'(quot_q);
  assign rsp_o.rem  = rem_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> ##4 rsp_o.done)
    else $error("divider result not on time");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> rsp_o.rem < gdn_pkg::div_const(sel3_q))
    else $error("divider remainder not reduced");

  a_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> (DW'(quot_q) * DW'(gdn_pkg::div_const(sel3_q)) + DW'(rem_q) == x3_q))
    else $error("divider quotient and remainder inconsistent");

endmodule

`default_nettype wire

FILE: src/gdn_core.sv
// gdn_core: sequencer and datapath of the day number converter; drives the
// shared divider and the year and month stepping. Depends on gdn_pkg, gdn_if.
`default_nettype none

module gdn_core #(
  parameter int unsigned YEAR_MAX = gdn_pkg::YEAR_MAX_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  gdn_req_if.sink                req_i,
  output gdn_pkg::div_req_t      div_req_o,
  input  wire gdn_pkg::div_rsp_t div_rsp_i,
  output logic                   res_valid_o,
  output gdn_pkg::result_t       res_o,
  input  wire logic              res_ready_i
);

  localparam int unsigned YW = gdn_pkg::YR_W;
  localparam int unsigned DW = gdn_pkg::DAY_W;
  localparam int unsigned SW = gdn_pkg::SUM_W;
  localparam int unsigned AW = gdn_pkg::ABS_W;
  localparam int unsigned MaxFixedInt =
    365 * YEAR_MAX + YEAR_MAX / 4 - YEAR_MAX / 100 + YEAR_MAX / 400;
  localparam logic [DW-1:0] MAX_FIXED = DW'(MaxFixedInt);

  gdn_pkg::state_e       state_q, state_d;
  logic [1:0]            op_q, op_d;
  logic [YW-1:0]         yr_q, yr_d;
  logic [3:0]            mon_q, mon_d;
  logic [4:0]            day_q, day_d;
  logic signed [3:0]     nth_q, nth_d;
  logic [2:0]            wday_q, wday_d;
  logic [DW-1:0]         abs_q, abs_d;
  logic signed [SW-1:0]  base_q, base_d;
  logic                  leap_q, leap_d;
  logic [6:0]            c100_q, c100_d;
  logic [8:0]            c400_q, c400_d;
  logic [8:0]            doy_q, doy_d;
  gdn_pkg::result_t      res_q, res_d;

  logic [YW-1:0]         p;
  logic [YW-1:0]         q100;
  logic [8:0]            r400;
  logic                  leap_p, leap_y, leap_n;
  logic [4:0]            mlen;
  logic signed [SW-1:0]  fix, rr, off, abs_s, doy_full;
  logic signed [4:0]     k;
  logic [YW-1:0]         y1;
  logic [8:0]            cum_next;

  // shared helper terms
  always_comb begin
    p        = yr_q - YW'(1);
    q100     = div_rsp_i.quot[YW-1:0];
    r400     = {7'd0, div_rsp_i.quot[1:0]} * 9'd100 + div_rsp_i.rem;
    leap_p   = (p[1:0] == 2'd3 && div_rsp_i.rem != 9'd99) || r400 == 9'd399;
    leap_y   = (yr_q[1:0] == 2'd0 && div_rsp_i.rem != 9'd0) || r400 == 9'd0;
    mlen     = gdn_pkg::month_len(mon_q, leap_p);
    fix      = base_q + SW'(gdn_pkg::cum_days(mon_q, leap_q)) + SW'(day_q);
    k        = (nth_q > 0) ? (5'(nth_q) - 5'sd1) : (5'(nth_q) + 5'sd1);
    off      = (SW'(k) <<< 3) - SW'(k);
    rr       = base_q - SW'(div_rsp_i.rem) + off;
    abs_s    = $signed({1'b0, abs_q});
    doy_full = abs_s - base_q + SW'(366) + SW'(leap_q);
    y1       = yr_q + YW'(1);
    leap_n   = (y1[1:0] == 2'd0 && c100_q != 7'd0) || c400_q == 9'd0;
    cum_next = gdn_pkg::cum_days(mon_q + 4'd1, leap_q);
  end

  // next state and outputs
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    yr_d    = yr_q;
    mon_d   = mon_q;
    day_d   = day_q;
    nth_d   = nth_q;
    wday_d  = wday_q;
    abs_d   = abs_q;
    base_d  = base_q;
    leap_d  = leap_q;
    c100_d  = c100_q;
    c400_d  = c400_q;
    doy_d   = doy_q;
    res_d   = res_q;
    req_i.ready         = 1'b0;
    res_valid_o         = 1'b0;
    div_req_o.start     = 1'b0;
    div_req_o.sel       = gdn_pkg::DIV_BY_100;
    div_req_o.dividend  = '0;

    case (state_q)
      gdn_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d    = req_i.operation;
          yr_d    = YW'(req_i.year_in);
          mon_d   = req_i.month_in;
          day_d   = req_i.day_in;
          abs_d   = DW'(req_i.absolute_in);
          nth_d   = req_i.nth;
          wday_d  = req_i.weekday;
          state_d = gdn_pkg::S_CHECK;
        end
      end
      gdn_pkg::S_CHECK: begin
        case (op_q)
          gdn_pkg::OP_TO_DATE: begin
            if (abs_q == '0 || abs_q > MAX_FIXED) begin
              state_d = gdn_pkg::S_ERR;
            end else begin
              state_d = gdn_pkg::S_YDIV_GO;
            end
          end
          gdn_pkg::OP_TO_ABS, gdn_pkg::OP_NTH_WDAY: begin
            if (yr_q == '0 || yr_q > YW'(YEAR_MAX) || mon_q == 4'd0 || mon_q > 4'd12) begin
              state_d = gdn_pkg::S_ERR;
            end else begin
              div_req_o.start    = 1'b1;
              div_req_o.sel      = gdn_pkg::DIV_BY_100;
              div_req_o.dividend = DW'(p);
              state_d            = gdn_pkg::S_LEAP;
            end
          end
          default: state_d = gdn_pkg::S_ERR;
        endcase
      end
      // leap rule and day check of the input date
      gdn_pkg::S_LEAP: begin
        if (div_rsp_i.done) begin
          base_d = SW'(gdn_pkg::year_base(p, q100));
          leap_d = leap_p;
          if (op_q == gdn_pkg::OP_TO_ABS) begin
            if (day_q == 5'd0 || day_q > mlen) begin
              state_d = gdn_pkg::S_ERR;
            end else begin
              state_d = gdn_pkg::S_FIX;
            end
          end else if (day_q > mlen) begin
            state_d = gdn_pkg::S_ERR;
          end else begin
            if (day_q == 5'd0) begin
              day_d = (nth_q > 0) ? 5'd1 : mlen;
            end
            state_d = gdn_pkg::S_FIX;
          end
        end
      end
      gdn_pkg::S_FIX: begin
        if (op_q == gdn_pkg::OP_TO_ABS) begin
          res_d              = '0;
          res_d.absolute_out = fix[AW-1:0];
          state_d            = gdn_pkg::S_DONE;
        end else begin
          base_d  = fix + ((nth_q > 0) ? SW'(6) : SW'(0));
          state_d = gdn_pkg::S_WK_GO;
        end
      end
      gdn_pkg::S_WK_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.sel      = gdn_pkg::DIV_BY_7;
        div_req_o.dividend = base_q[DW-1:0] + DW'(7) - DW'(wday_q);
        state_d            = gdn_pkg::S_WK;
      end
      // on-or-before weekday, then step whole weeks
      gdn_pkg::S_WK: begin
        if (div_rsp_i.done) begin
          if (rr[SW-1] || rr == '0 || rr[DW-1:0] > MAX_FIXED) begin
            state_d = gdn_pkg::S_ERR;
          end else begin
            abs_d   = rr[DW-1:0];
            state_d = gdn_pkg::S_YDIV_GO;
          end
        end
      end
      gdn_pkg::S_YDIV_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.sel      = gdn_pkg::DIV_BY_366;
        div_req_o.dividend = abs_q;
        state_d            = gdn_pkg::S_YDIV;
      end
      gdn_pkg::S_YDIV: begin
        if (div_rsp_i.done) begin
          yr_d    = div_rsp_i.quot[YW-1:0];
          state_d = gdn_pkg::S_YCEN_GO;
        end
      end
      gdn_pkg::S_YCEN_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.sel      = gdn_pkg::DIV_BY_100;
        div_req_o.dividend = DW'(yr_q);
        state_d            = gdn_pkg::S_YCEN;
      end
      // start of the following year and leap counters for the estimate
      gdn_pkg::S_YCEN: begin
        if (div_rsp_i.done) begin
          base_d  = SW'(gdn_pkg::year_base(yr_q, q100) + DW'(1));
          leap_d  = leap_y;
          c100_d  = (div_rsp_i.rem == 9'd99) ? 7'd0 : div_rsp_i.rem[6:0] + 7'd1;
          c400_d  = (r400 == 9'd399) ? 9'd0 : r400 + 9'd1;
          state_d = gdn_pkg::S_YEAR;
        end
      end
      // step the year up one per cycle
      gdn_pkg::S_YEAR: begin
        if (abs_s >= base_q) begin
          yr_d   = y1;
          base_d = base_q + SW'(365) + SW'(leap_n);
          leap_d = leap_n;
          c100_d = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
          c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        end else begin
          doy_d   = doy_full[8:0];
          mon_d   = 4'd1;
          state_d = gdn_pkg::S_MONTH;
        end
      end
      // step the month up one per cycle
      gdn_pkg::S_MONTH: begin
        if (mon_q < 4'd12 && doy_q > cum_next) begin
          mon_d = mon_q + 4'd1;
        end else begin
          res_d.year_out     = yr_q[gdn_pkg::YEAR_W-1:0];
          res_d.month_out    = mon_q;
          res_d.day_out      = 5'(doy_q - gdn_pkg::cum_days(mon_q, leap_q));
          res_d.absolute_out = abs_q[AW-1:0];
          res_d.out_of_range = 1'b0;
          state_d            = gdn_pkg::S_DONE;
        end
      end
      gdn_pkg::S_ERR: begin
        res_d              = '0;
        res_d.out_of_range = 1'b1;
        state_d            = gdn_pkg::S_DONE;
      end
      gdn_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = gdn_pkg::S_IDLE;
        end
      end
      default: state_d = gdn_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdn_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    yr_q   <= yr_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    nth_q  <= nth_d;
    wday_q <= wday_d;
    abs_q  <= abs_d;
    base_q <= base_d;
    leap_q <= leap_d;
    c100_q <= c100_d;
    c400_q <= c400_d;
    doy_q  <= doy_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_of_range |->
      res_o.year_out == '0 && res_o.month_out == '0 && res_o.day_out == '0 &&
      res_o.absolute_out == '0)
    else $error("error result carries nonzero fields");

  a_div_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> state_q == gdn_pkg::S_LEAP || state_q == gdn_pkg::S_WK ||
                       state_q == gdn_pkg::S_YDIV || state_q == gdn_pkg::S_YCEN)
    else $error("divider result arrived outside a wait state");

  a_year_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gdn_pkg::S_YEAR |-> abs_s >= base_q - SW'(366))
    else $error("year estimate above the target day");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gdn_pkg::S_MONTH |-> mon_q >= 4'd1 && mon_q <= 4'd12)
    else $error("month search left the year");

endmodule

`default_nettype wire
